>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. Defining NO_ASSERTIONS compiles them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
	else $error("%m: assertion failed");

// Checks that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
	else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> hw/rtl/css_pkg.sv
package css_pkg;

	localparam int unsigned DEFAULT_MAX_BUFFER_BYTES = 32'd65535;

	localparam int CFG_DATA_W = 7;
	localparam int CFG_INDEX_W = 1;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_MATCH_ANY_FINAL = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WANTED_FINAL = 1'd1;

	localparam logic RESET_MATCH_ANY_FINAL = 1'b1;
	localparam logic [6:0] RESET_WANTED_FINAL = 7'd109;

	localparam logic [7:0] B_ESC = 8'h1B;
	localparam logic [7:0] B_LBRACKET = 8'h5B;
	localparam logic [7:0] B_PARAM_LO = 8'h30;
	localparam logic [7:0] B_PARAM_HI = 8'h3F;
	localparam logic [7:0] B_INTER_LO = 8'h20;
	localparam logic [7:0] B_INTER_HI = 8'h2F;
	localparam logic [7:0] B_FINAL_LO = 8'h40;
	localparam logic [7:0] B_FINAL_HI = 8'h7E;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_ESC   = 3'd1,
		PH_PARAM = 3'd2,
		PH_INTER = 3'd3,
		PH_DONE  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_COMPLETE = 2'd0,
		ST_PARTIAL  = 2'd1,
		ST_NONE     = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} css_in_t;

	typedef struct packed {
		logic [1:0]  scan_status;
		logic [15:0] start_offset;
		logic [15:0] seq_length;
	} css_out_t;

endpackage

>>> hw/rtl/csi_sequence_scanner.sv
// CSI sequence scanner. Bytes of a buffer arrive on the byte channel (valid/ready),
// one per transfer, with last_byte set on the final byte. The block looks for the
// first ESC '[' params intermediates final sequence and gives exactly one result
// per buffer on the result channel: a complete match as soon as its final byte is
// seen, otherwise a partial-sequence or nothing-found result on the last byte.
// After a match the rest of the buffer is consumed without results.
// A byte is taken into an input register, then the phase machine, position counter
// and candidate start are updated in the same cycle as any result is written into
// the output register. A result is valid once its byte has passed the input and
// output registers, and one byte per cycle is accepted as long as results are taken.
// When the receiver stalls, a waiting result holds the output register; one more
// byte is still taken into the input register, after which byte_ready drops.
// Reset clears the phase to searching, the position and candidate start to zero,
// empties both registers and restores match_any_final = 1 and wanted_final = 'm'.
// Configuration writes on cfg_we must be made while idle; the block does not check.
// Positions and lengths saturate at MAX_BUFFER_BYTES and are reported in 16 bits.
module csi_sequence_scanner #(
	parameter int unsigned MAX_BUFFER_BYTES = css_pkg::DEFAULT_MAX_BUFFER_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             byte_valid,
	output logic                             byte_ready,
	input  css_pkg::css_in_t                 byte_item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output css_pkg::css_out_t                result_item,
	input  logic                             cfg_we,
	input  logic [css_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [css_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import css_pkg::*;

	localparam int POS_W = $clog2(64'(MAX_BUFFER_BYTES) + 64'd1);
	localparam int LEN_W = POS_W + 1;
	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_BUFFER_BYTES);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BUFFER_BYTES);

	logic             valid_s1;
	css_in_t          byte_s1;
	logic             result_valid_s2;
	css_out_t         result_s2;

	phase_t           phase_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] cand_q;
	logic             match_any_q;
	logic [6:0]       wanted_q;

	phase_t           phase_nx;
	logic [POS_W-1:0] cand_nx;
	logic             found;
	logic             seek;
	logic             final_ok;
	logic             advance;
	logic             has_result;
	logic [7:0]       b;
	logic [LEN_W-1:0] len_raw;
	logic [LEN_W-1:0] len_sat;
	logic [LEN_W-1:0] pos_inc;
	logic [POS_W-1:0] pos_sat;
	css_out_t         result_nx;

	assign b = byte_s1.data_byte;

	// The input register item moves on whenever the output register can take a result.
	assign advance = valid_s1 && (!result_valid_s2 || result_ready);
	assign byte_ready = !valid_s1 || advance;

	assign final_ok = (b inside {[B_FINAL_LO:B_FINAL_HI]}) &&
		(match_any_q || (b == {1'b0, wanted_q}));

	// Next state of the phase machine.
	always_comb begin
		phase_nx = phase_q;
		cand_nx = cand_q;
		found = 1'b0;
		seek = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				seek = 1'b1;
			end
			PH_ESC: begin
				if (b == B_LBRACKET) begin
					phase_nx = PH_PARAM;
				end else begin
					seek = 1'b1;
				end
			end
			PH_PARAM: begin
				if (b inside {[B_PARAM_LO:B_PARAM_HI]}) begin
					phase_nx = PH_PARAM;
				end else if (b inside {[B_INTER_LO:B_INTER_HI]}) begin
					phase_nx = PH_INTER;
				end else if (final_ok) begin
					phase_nx = PH_DONE;
					found = 1'b1;
				end else begin
					seek = 1'b1;
				end
			end
			PH_INTER: begin
				if (b inside {[B_INTER_LO:B_INTER_HI]}) begin
					phase_nx = PH_INTER;
				end else if (final_ok) begin
					phase_nx = PH_DONE;
					found = 1'b1;
				end else begin
					seek = 1'b1;
				end
			end
			default: begin
				phase_nx = PH_DONE;
			end
		endcase
		// A rejected byte is searched again, so an ESC here opens a new candidate.
		if (seek) begin
			if (b == B_ESC) begin
				phase_nx = PH_ESC;
				cand_nx = pos_q;
			end else begin
				phase_nx = PH_IDLE;
			end
		end
	end

	// Result and position arithmetic.
	always_comb begin
		len_raw = LEN_W'(pos_q) - LEN_W'(cand_nx) + LEN_W'(1);
		len_sat = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
		pos_inc = LEN_W'(pos_q) + LEN_W'(1);
		pos_sat = (pos_inc > MAX_LEN) ? MAX_POS : pos_inc[POS_W-1:0];
		has_result = found || (byte_s1.last_byte && (phase_nx != PH_DONE));
		result_nx.start_offset = 16'(cand_nx);
		result_nx.seq_length = 16'(len_sat);
		if (found) begin
			result_nx.scan_status = ST_COMPLETE;
		end else if (phase_nx == PH_IDLE) begin
			result_nx.scan_status = ST_NONE;
			result_nx.start_offset = '0;
			result_nx.seq_length = '0;
		end else begin
			result_nx.scan_status = ST_PARTIAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q <= '0;
			cand_q <= '0;
		end else if (advance) begin
			if (byte_s1.last_byte) begin
				phase_q <= PH_IDLE;
				pos_q <= '0;
				cand_q <= '0;
			end else begin
				phase_q <= phase_nx;
				pos_q <= pos_sat;
				cand_q <= cand_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= has_result;
		end else if (result_ready) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_s2 <= result_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_any_q <= RESET_MATCH_ANY_FINAL;
			wanted_q <= RESET_WANTED_FINAL;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MATCH_ANY_FINAL: match_any_q <= cfg_data[0];
				REG_WANTED_FINAL:    wanted_q <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	assign result_valid = result_valid_s2;
	assign result_item = result_s2;

`include "assert_macros.svh"

	`ASSERT_CLK(a_cand_not_after_pos, clk, arst_n, cand_q <= pos_q)
	`ASSERT_CLK(a_pos_saturated, clk, arst_n, pos_q <= MAX_POS)
	`ASSERT_CLK(a_last_restarts, clk, arst_n,
		(advance && byte_s1.last_byte) |=> (phase_q == PH_IDLE && pos_q == '0))
	`ASSERT_NEVER(a_stall_only_when_full, clk, arst_n, !byte_ready && !valid_s1)
	`ASSERT_CLK(a_none_is_zero, clk, arst_n,
		(result_valid_s2 && result_s2.scan_status == ST_NONE) |->
		(result_s2.start_offset == '0 && result_s2.seq_length == '0))

endmodule
